### design/pbb_pkg.sv
// Shared types, constants and register codes for the projection bounding box block.
`timescale 1ns / 1ps

package pbb_pkg;

    localparam int CFG_W     = 11;
    localparam int COUNT_W   = 11;
    localparam int OUT_W     = 10;
    localparam int PIX_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int RES_W     = 6 * OUT_W;
    localparam int TDATA_W   = ((RES_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [PIX_W-1:0]   SKIN_BYTE = 8'hFF;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH   = 11'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT  = 11'd480;
    localparam logic [CFG_W-1:0] RST_COL_THRESHOLD = 11'd8;
    localparam logic [CFG_W-1:0] RST_ROW_THRESHOLD = 11'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_COL_THRESHOLD = 2'd2,
        REG_ROW_THRESHOLD = 2'd3
    } cfg_reg_t;

    // Control that travels with one pixel from the scan counters to the column stage.
    typedef struct packed {
        logic valid;
        logic skin;
        logic first_row;
        logic frame_end;
    } pixel_ctl_t;

    // One result; left_col sits in the lowest bits.
    typedef struct packed {
        logic [OUT_W-1:0] box_height;
        logic [OUT_W-1:0] box_width;
        logic [OUT_W-1:0] bottom_row;
        logic [OUT_W-1:0] top_row;
        logic [OUT_W-1:0] right_col;
        logic [OUT_W-1:0] left_col;
    } result_t;

endpackage

### design/projection_bounding_box.sv
// Top level of the projection bounding box: configuration registers and stream ports.
// m_tvalid rises once the last pixel of a frame has passed the column stage into the buffer.
// Throughput: one pixel per cycle, set by the column-count memory that reads one column while
// writing back the previous one; s_tready drops once queued plus pending results reach three.
// Reset: configuration returns to 640 x 480 with both thresholds at 8 and the scan restarts;
// the column-count memory is not cleared, as the first row of each frame overwrites it.
`timescale 1ns / 1ps

module projection_bounding_box
    import pbb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Pixel stream in.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PIX_W-1:0]     s_tdata,    // [7:0] mask_value
    // Result stream out.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,    // [9:0] left_col, [19:10] right_col,
                                             // [29:20] top_row, [39:30] bottom_row,
                                             // [49:40] box_width, [59:50] box_height
    // Configuration writes.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);

    logic [CFG_W-1:0] frame_width_reg, frame_width_next;
    logic [CFG_W-1:0] frame_height_reg, frame_height_next;
    logic [CFG_W-1:0] col_thr_reg, col_thr_next;
    logic [CFG_W-1:0] row_thr_reg, row_thr_next;

    logic             cfg_write;
    logic             accept;
    pixel_ctl_t       pix;
    logic [XW-1:0]    col;
    logic [YW-1:0]    frame_top;
    logic [YW-1:0]    frame_bottom;
    logic             push;
    logic             pending;
    result_t          result;
    result_t          out_result;
    logic [1:0]       level;

    // Configuration is always taken; a write lands in the register named by its index.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        col_thr_next      = col_thr_reg;
        row_thr_next      = row_thr_reg;
        if (cfg_write) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:   frame_width_next  = cfg_data;
                REG_FRAME_HEIGHT:  frame_height_next = cfg_data;
                REG_COL_THRESHOLD: col_thr_next      = cfg_data;
                REG_ROW_THRESHOLD: row_thr_next      = cfg_data;
                default:           frame_width_next  = frame_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            col_thr_reg      <= RST_COL_THRESHOLD;
            row_thr_reg      <= RST_ROW_THRESHOLD;
        end
        else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            col_thr_reg      <= col_thr_next;
            row_thr_reg      <= row_thr_next;
        end
    end

    // A pixel is taken only when the result buffer is sure to have room for whatever the
    // pixel in the column stage and this one may produce. Counting the result still in the
    // column stage keeps the buffer from overflowing even for one-pixel frames.
    assign s_tready = ({1'b0, level} + {2'b00, pending}) < 3'd3;
    assign accept   = s_tvalid && s_tready;

    // Stage zero: raster counters and row bounds, updated at the pixel transfer.
    pbb_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .mask_value    (s_tdata),
        .frame_width   (frame_width_reg),
        .frame_height  (frame_height_reg),
        .row_threshold (row_thr_reg),
        .pix           (pix),
        .col           (col),
        .frame_top     (frame_top),
        .frame_bottom  (frame_bottom)
    );

    // Stage one: column count read-modify-write and column bounds; forms the result.
    pbb_col_update #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_col_update (
        .clk              (clk),
        .rst_n            (rst_n),
        .pix              (pix),
        .col              (col),
        .frame_top        (frame_top),
        .frame_bottom     (frame_bottom),
        .column_threshold (col_thr_reg),
        .push             (push),
        .result           (result),
        .pending          (pending)
    );

    pbb_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din       (result),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .dout      (out_result),
        .level     (level)
    );

    assign m_tdata = TDATA_W'(out_result);

endmodule

### design/pbb_scan.sv
// Raster position counters, row skin count and row bound tracking.
`timescale 1ns / 1ps

module pbb_scan
    import pbb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int YW = $clog2(MAX_HEIGHT)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [PIX_W-1:0]  mask_value,
    input  logic [CFG_W-1:0]  frame_width,
    input  logic [CFG_W-1:0]  frame_height,
    input  logic [CFG_W-1:0]  row_threshold,
    output pixel_ctl_t        pix,
    output logic [XW-1:0]     col,
    output logic [YW-1:0]     frame_top,
    output logic [YW-1:0]     frame_bottom
);

    localparam int CMPX_W = (XW + 1 > CFG_W) ? XW + 1 : CFG_W;
    localparam int CMPY_W = (YW + 1 > CFG_W) ? YW + 1 : CFG_W;

    logic [XW-1:0]      col_pos_reg, col_pos_next;
    logic [YW-1:0]      row_pos_reg, row_pos_next;
    logic [COUNT_W-1:0] row_count_reg, row_count_next;
    logic [YW-1:0]      top_reg, top_next;
    logic [YW-1:0]      bottom_reg, bottom_next;
    logic               row_found_reg, row_found_next;
    logic [YW-1:0]      frame_top_reg, frame_top_next;
    logic [YW-1:0]      frame_bottom_reg, frame_bottom_next;

    logic [CFG_W-1:0]   w_used;
    logic [CFG_W-1:0]   h_used;
    logic               skin;
    logic [COUNT_W-1:0] row_count_inc;
    logic               row_end;
    logic               frame_end;
    logic               row_hit;
    logic [YW-1:0]      top_upd;
    logic [YW-1:0]      bottom_upd;
    logic               found_upd;

    // A size of zero acts as one, a size above the maximum acts as the maximum.
    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input int unsigned maxv);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end
        else if (32'(v) > maxv) begin
            r = CFG_W'(maxv);
        end
        else begin
            r = v;
        end
        return r;
    endfunction

    always_comb
    begin
        w_used        = clamp_size(frame_width, MAX_WIDTH);
        h_used        = clamp_size(frame_height, MAX_HEIGHT);
        skin          = (mask_value == SKIN_BYTE);
        row_count_inc = row_count_reg
                        + COUNT_W'(skin && (row_count_reg != COUNT_MAX));
        row_end       = (CMPX_W'(col_pos_reg) + CMPX_W'(1)) >= CMPX_W'(w_used);
        frame_end     = row_end
                        && ((CMPY_W'(row_pos_reg) + CMPY_W'(1)) >= CMPY_W'(h_used));
        row_hit       = (row_count_inc >= row_threshold);
        top_upd       = (row_hit && !row_found_reg) ? row_pos_reg : top_reg;
        bottom_upd    = row_hit ? row_pos_reg : bottom_reg;
        found_upd     = row_found_reg || row_hit;
    end

    always_comb
    begin
        col_pos_next      = col_pos_reg;
        row_pos_next      = row_pos_reg;
        row_count_next    = row_count_reg;
        top_next          = top_reg;
        bottom_next       = bottom_reg;
        row_found_next    = row_found_reg;
        frame_top_next    = frame_top_reg;
        frame_bottom_next = frame_bottom_reg;
        if (accept) begin
            if (!row_end) begin
                col_pos_next   = col_pos_reg + XW'(1);
                row_count_next = row_count_inc;
            end
            else begin
                col_pos_next   = '0;
                row_count_next = '0;
                if (!frame_end) begin
                    row_pos_next   = row_pos_reg + YW'(1);
                    top_next       = top_upd;
                    bottom_next    = bottom_upd;
                    row_found_next = found_upd;
                end
                else begin
                    // Hand the finished row bounds to the column stage and start over.
                    row_pos_next      = '0;
                    top_next          = '0;
                    bottom_next       = '0;
                    row_found_next    = 1'b0;
                    frame_top_next    = top_upd;
                    frame_bottom_next = bottom_upd;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
            row_count_reg <= '0;
            top_reg       <= '0;
            bottom_reg    <= '0;
            row_found_reg <= 1'b0;
        end
        else begin
            col_pos_reg   <= col_pos_next;
            row_pos_reg   <= row_pos_next;
            row_count_reg <= row_count_next;
            top_reg       <= top_next;
            bottom_reg    <= bottom_next;
            row_found_reg <= row_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_top_reg    <= frame_top_next;
        frame_bottom_reg <= frame_bottom_next;
    end

    assign pix.valid     = accept;
    assign pix.skin      = skin;
    assign pix.first_row = (row_pos_reg == '0);
    assign pix.frame_end = frame_end;
    assign col           = col_pos_reg;
    assign frame_top     = frame_top_reg;
    assign frame_bottom  = frame_bottom_reg;

endmodule

### design/pbb_col_update.sv
// Column count memory with read-modify-write, forwarding and column bound tracking.
`timescale 1ns / 1ps

module pbb_col_update
    import pbb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int YW = $clog2(MAX_HEIGHT)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  pixel_ctl_t        pix,
    input  logic [XW-1:0]     col,
    input  logic [YW-1:0]     frame_top,
    input  logic [YW-1:0]     frame_bottom,
    input  logic [CFG_W-1:0]  column_threshold,
    output logic              push,
    output result_t           result,
    output logic              pending
);

    logic [COUNT_W-1:0] count_mem [MAX_WIDTH];

    logic               s1_valid_reg;
    logic [XW-1:0]      s1_col_reg;
    logic               s1_skin_reg;
    logic               s1_first_reg;
    logic               s1_last_reg;
    logic [COUNT_W-1:0] rdata_reg;
    logic               fwd_hit_reg;
    logic [COUNT_W-1:0] fwd_data_reg;

    logic [XW-1:0]      left_reg, left_next;
    logic [XW-1:0]      right_reg, right_next;
    logic               col_found_reg, col_found_next;

    logic [COUNT_W-1:0] base_count;
    logic [COUNT_W-1:0] new_count;
    logic               col_hit;
    logic [XW-1:0]      left_upd;
    logic [XW-1:0]      right_upd;
    logic               found_upd;

    // The first row of a frame overwrites the stale count instead of adding to it.
    always_comb
    begin
        if (s1_first_reg) begin
            base_count = '0;
        end
        else if (fwd_hit_reg) begin
            base_count = fwd_data_reg;
        end
        else begin
            base_count = rdata_reg;
        end
        new_count = base_count + COUNT_W'(s1_skin_reg && (base_count != COUNT_MAX));
        col_hit   = (new_count >= column_threshold);
        left_upd  = left_reg;
        right_upd = right_reg;
        found_upd = col_found_reg || col_hit;
        if (col_hit) begin
            if (!col_found_reg) begin
                left_upd  = s1_col_reg;
                right_upd = s1_col_reg;
            end
            else begin
                if (s1_col_reg < left_reg) begin
                    left_upd = s1_col_reg;
                end
                if (s1_col_reg > right_reg) begin
                    right_upd = s1_col_reg;
                end
            end
        end
    end

    always_comb
    begin
        left_next      = left_reg;
        right_next     = right_reg;
        col_found_next = col_found_reg;
        if (s1_valid_reg) begin
            if (s1_last_reg) begin
                left_next      = '0;
                right_next     = '0;
                col_found_next = 1'b0;
            end
            else begin
                left_next      = left_upd;
                right_next     = right_upd;
                col_found_next = found_upd;
            end
        end
    end

    // The read for a new pixel and the write-back of the previous one share an edge;
    // when both hit the same column the written value is forwarded.
    always_ff @(posedge clk)
    begin
        if (pix.valid) begin
            rdata_reg <= count_mem[col];
        end
        if (s1_valid_reg) begin
            count_mem[s1_col_reg] <= new_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix.valid) begin
            s1_col_reg   <= col;
            s1_skin_reg  <= pix.skin;
            s1_first_reg <= pix.first_row;
            s1_last_reg  <= pix.frame_end;
            fwd_hit_reg  <= s1_valid_reg && (s1_col_reg == col);
            fwd_data_reg <= new_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            left_reg      <= '0;
            right_reg     <= '0;
            col_found_reg <= 1'b0;
        end
        else begin
            s1_valid_reg  <= pix.valid;
            left_reg      <= left_next;
            right_reg     <= right_next;
            col_found_reg <= col_found_next;
        end
    end

    assign push    = s1_valid_reg && s1_last_reg;
    assign pending = s1_valid_reg && s1_last_reg;

    assign result.left_col   = OUT_W'(left_upd);
    assign result.right_col  = OUT_W'(right_upd);
    assign result.top_row    = OUT_W'(frame_top);
    assign result.bottom_row = OUT_W'(frame_bottom);
    assign result.box_width  = OUT_W'(right_upd - left_upd);
    assign result.box_height = OUT_W'(frame_bottom - frame_top);

endmodule

### design/pbb_out_buf.sv
// Three-entry result buffer in front of the master stream port.
`timescale 1ns / 1ps

module pbb_out_buf
    import pbb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  result_t     din,
    input  logic        out_ready,
    output logic        out_valid,
    output result_t     dout,
    output logic [1:0]  level
);

    localparam int         DEPTH     = 3;
    localparam logic [1:0] LAST_SLOT = 2'(DEPTH - 1);

    result_t    slot_reg [DEPTH];
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    always_comb
    begin
        pop         = (count_reg != 2'd0) && out_ready;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? 2'd0 : rd_ptr_reg + 2'd1;
        end
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? 2'd0 : wr_ptr_reg + 2'd1;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rd_ptr_reg <= 2'd0;
            wr_ptr_reg <= 2'd0;
            count_reg  <= 2'd0;
        end
        else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    assign out_valid = (count_reg != 2'd0);
    assign dout      = slot_reg[rd_ptr_reg];
    assign level     = count_reg;

endmodule
